// ----- src/rpic_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rpic_pkg
// Shared types and constants of the root port interrupt controller: register
// offsets, bit positions, operation codes and the ring entry format.
// ----------------------------------------------------------------------------
package rpic_pkg;

  localparam int RING_DEPTH = 16;
  localparam int RING_AW    = $clog2(RING_DEPTH);

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_LINE  = 2'd2,
    OP_MSI   = 2'd3
  } op_t;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIFO_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINK_UP   = 1'd1;

  localparam logic [11:0] A_STATUS  = 12'h138;
  localparam logic [11:0] A_IMASK   = 12'h13c;
  localparam logic [11:0] A_PHY     = 12'h144;
  localparam logic [11:0] A_RPSC    = 12'h148;
  localparam logic [11:0] A_MSIB_HI = 12'h14c;
  localparam logic [11:0] A_MSIB_LO = 12'h150;
  localparam logic [11:0] A_RING1   = 12'h158;
  localparam logic [11:0] A_RING2   = 12'h15c;
  localparam logic [11:0] A_DEC     = 12'h160;
  localparam logic [11:0] A_DECMASK = 12'h164;
  localparam logic [11:0] A_MSI_LO  = 12'h170;
  localparam logic [11:0] A_MSI_HI  = 12'h174;
  localparam logic [11:0] A_MSIM_LO = 12'h178;
  localparam logic [11:0] A_MSIM_HI = 12'h17c;

  localparam int INTX_POS   = 16;
  localparam int LINK_POS   = 11;
  localparam int NEMPTY_POS = 18;
  localparam int OVF_POS    = 19;
  localparam int LANE_POS   = 27;
  localparam int LEVEL_POS  = 29;
  localparam int VALID_POS  = 31;
  localparam int DEC_POS    = 16;
  localparam int MSIB_LSB   = 12;

  typedef struct packed {
    logic       level;
    logic [1:0] line;
  } ring_entry_t;

  typedef struct packed {
    logic        push;
    logic        pop;
    ring_entry_t entry;
  } ring_ctl_t;

  typedef struct packed {
    logic        empty;
    logic        full;
    ring_entry_t head;
  } ring_stat_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_out;
    logic        msi_irq_low;
    logic        msi_irq_high;
    logic        bridge_on;
  } res_t;

endpackage
`default_nettype wire

// ----- src/rpic_ring.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rpic_ring
// Legacy interrupt event ring: one slot kept free, head shown combinationally.
// ----------------------------------------------------------------------------
module rpic_ring (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire rpic_pkg::ring_ctl_t ctl,
  output rpic_pkg::ring_stat_t     stat
);
  import rpic_pkg::*;

  ring_entry_t        mem [RING_DEPTH];
  logic [RING_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [RING_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [RING_AW-1:0] wr_inc;

  always_comb begin
    wr_inc = (wr_ptr_r == RING_AW'(RING_DEPTH - 1)) ? '0 : wr_ptr_r + RING_AW'(1);
    wr_ptr_nxt = ctl.push ? wr_inc : wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (ctl.pop) begin
      rd_ptr_nxt = (rd_ptr_r == RING_AW'(RING_DEPTH - 1)) ? '0 : rd_ptr_r + RING_AW'(1);
    end
  end

  assign stat.empty = (rd_ptr_r == wr_ptr_r);
  assign stat.full  = (wr_inc == rd_ptr_r);
  assign stat.head  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[wr_ptr_r] <= ctl.entry;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.push |-> !stat.full) else $error("push into full ring");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.pop |-> !stat.empty) else $error("pop from empty ring");
  a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.push && !ctl.pop |=> !stat.empty) else $error("ring empty after push");

endmodule
`default_nettype wire

// ----- src/pcie_root_interrupt_controller.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pcie_root_interrupt_controller
// Interrupt side of a PCIe root port: register window, legacy event ring,
// line decode register and 64 MSI pending bits with masks.
// ----------------------------------------------------------------------------
// Path: an accepted beat passes the input register, then the result
//   register, which presents it on the result port.
// Throughput: one beat per cycle; each beat is a single read-modify-write of
//   the register file in the stage after the input register. The input
//   stalls only while the skid slot holds a beat behind a stalled output.
// Reset: all interrupt state, masks and ring pointers clear; fifo_mode and
//   link_is_up come up set. Ring contents stay undefined until written.
// ----------------------------------------------------------------------------
module pcie_root_interrupt_controller (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // input channel
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [1:0]                         in_operation,
  input  wire logic [11:0]                        in_reg_address,
  input  wire logic [31:0]                        in_write_data,
  input  wire logic [1:0]                         in_irq_line,
  input  wire logic                               in_irq_level,
  // result channel
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [31:0]                             out_read_data,
  output logic                                    out_irq_out,
  output logic                                    out_msi_irq_low,
  output logic                                    out_msi_irq_high,
  output logic                                    out_bridge_on,
  // configuration channel
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [rpic_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic                               cfg_wdata
);
  import rpic_pkg::*;

  // configuration registers
  logic fifo_mode_r;
  logic link_up_r;

  // input register stage
  logic        s1_valid_r;
  op_t         s1_op_r;
  logic [11:0] s1_addr_r;
  logic [31:0] s1_data_r;
  logic [1:0]  s1_line_r;
  logic        s1_level_r;

  // interrupt state
  logic        pend_r,     pend_nxt;
  logic [31:0] imask_r,    imask_nxt;
  logic        bridge_r,   bridge_nxt;
  logic        ovf_r,      ovf_nxt;
  logic [31:0] msib_hi_r,  msib_hi_nxt;
  logic [31:MSIB_LSB] msib_lo_r, msib_lo_nxt;
  logic [3:0]  dec_r,      dec_nxt;
  logic [31:0] decmask_r,  decmask_nxt;
  logic [63:0] msi_pend_r, msi_pend_nxt;
  logic [63:0] msi_mask_r, msi_mask_nxt;

  // result side: output register plus one skid slot
  logic out_valid_r;
  logic skid_valid_r;
  res_t out_r;
  res_t skid_r;
  res_t res;

  logic       in_acc;
  logic       res_go;
  logic       out_take;
  logic       recomp;
  logic [63:0] msi_active;
  ring_ctl_t  ring_ctl;
  ring_stat_t ring_stat;

  rpic_ring u_ring (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ring_ctl),
    .stat  (ring_stat)
  );

  // Hold the input register while it holds a beat and the skid slot is occupied.
  assign in_stall  = s1_valid_r && skid_valid_r;
  assign in_acc    = in_valid && !in_stall;
  assign res_go    = s1_valid_r && !skid_valid_r;
  assign out_take  = out_valid_r && !out_stall;
  assign cfg_ready = 1'b1;

  // Read-modify-write of the register file for the beat in the input register.
  always_comb begin
    pend_nxt     = pend_r;
    imask_nxt    = imask_r;
    bridge_nxt   = bridge_r;
    ovf_nxt      = ovf_r;
    msib_hi_nxt  = msib_hi_r;
    msib_lo_nxt  = msib_lo_r;
    dec_nxt      = dec_r;
    decmask_nxt  = decmask_r;
    msi_pend_nxt = msi_pend_r;
    msi_mask_nxt = msi_mask_r;
    ring_ctl       = '0;
    ring_ctl.entry = '{level: s1_level_r, line: s1_line_r};
    res.read_data  = '0;

    if (s1_valid_r && res_go) begin
      case (s1_op_r)
        OP_READ: begin
          unique case (s1_addr_r)
            A_STATUS:  res.read_data[INTX_POS] = pend_r;
            A_IMASK:   res.read_data = imask_r;
            A_PHY:     res.read_data[LINK_POS] = link_up_r;
            A_RPSC: begin
              res.read_data[0]          = bridge_r;
              res.read_data[NEMPTY_POS] = !ring_stat.empty;
              res.read_data[OVF_POS]    = ovf_r;
            end
            A_MSIB_HI: res.read_data = msib_hi_r;
            A_MSIB_LO: res.read_data[31:MSIB_LSB] = msib_lo_r;
            A_RING1: begin
              if (!ring_stat.empty) begin
                res.read_data[LANE_POS +: 2] = ring_stat.head.line;
                res.read_data[LEVEL_POS]     = ring_stat.head.level;
                res.read_data[VALID_POS]     = 1'b1;
              end
            end
            A_DEC:     res.read_data[DEC_POS +: 4] = dec_r;
            A_DECMASK: res.read_data = decmask_r;
            A_MSI_LO:  res.read_data = msi_pend_r[31:0];
            A_MSI_HI:  res.read_data = msi_pend_r[63:32];
            A_MSIM_LO: res.read_data = msi_mask_r[31:0];
            A_MSIM_HI: res.read_data = msi_mask_r[63:32];
            default:   res.read_data = '0;
          endcase
        end
        OP_WRITE: begin
          unique case (s1_addr_r)
            A_STATUS: begin
              if (s1_data_r[INTX_POS]) begin
                pend_nxt = 1'b0;
              end
            end
            A_IMASK:   imask_nxt = s1_data_r;
            A_RPSC:    bridge_nxt = s1_data_r[0];
            A_MSIB_HI: msib_hi_nxt = s1_data_r;
            A_MSIB_LO: msib_lo_nxt = s1_data_r[31:MSIB_LSB];
            A_RING1, A_RING2: ring_ctl.pop = !ring_stat.empty;
            A_DECMASK: decmask_nxt = s1_data_r;
            A_MSI_LO:  msi_pend_nxt[31:0]  = msi_pend_r[31:0] & ~s1_data_r;
            A_MSI_HI:  msi_pend_nxt[63:32] = msi_pend_r[63:32] & ~s1_data_r;
            A_MSIM_LO: msi_mask_nxt[31:0]  = s1_data_r;
            A_MSIM_HI: msi_mask_nxt[63:32] = s1_data_r;
            default: ;
          endcase
        end
        OP_LINE: begin
          if (fifo_mode_r) begin
            // Drop the event on a full ring and flag the loss.
            if (ring_stat.full) begin
              ovf_nxt = 1'b1;
            end else begin
              ring_ctl.push = 1'b1;
              pend_nxt      = 1'b1;
            end
          end else begin
            dec_nxt[s1_line_r] = s1_level_r;
          end
        end
        default: begin
          if (!fifo_mode_r) begin
            msi_pend_nxt[s1_data_r[5:0]] = 1'b1;
          end
        end
      endcase

      // Re-set the pending bit while its source persists; a dropped event
      // leaves it alone.
      recomp = fifo_mode_r ? !ring_stat.empty
                           : |(dec_nxt & decmask_nxt[DEC_POS +: 4]);
      if ((s1_op_r == OP_LINE && !(fifo_mode_r && ring_stat.full)) ||
          (s1_op_r == OP_WRITE &&
           (s1_addr_r == A_STATUS || s1_addr_r == A_IMASK ||
            s1_addr_r == A_DECMASK))) begin
        pend_nxt = pend_nxt | recomp;
      end
    end else begin
      recomp = 1'b0;
    end

    msi_active       = msi_pend_nxt & msi_mask_nxt;
    res.irq_out      = pend_nxt && imask_nxt[INTX_POS];
    res.msi_irq_low  = !fifo_mode_r && (|msi_active[31:0]);
    res.msi_irq_high = !fifo_mode_r && (|msi_active[63:32]);
    res.bridge_on    = bridge_nxt;
  end

  // Control state: config, pipeline valids, interrupt registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fifo_mode_r  <= 1'b1;
      link_up_r    <= 1'b1;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
      pend_r       <= 1'b0;
      imask_r      <= '0;
      bridge_r     <= 1'b0;
      ovf_r        <= 1'b0;
      msib_hi_r    <= '0;
      msib_lo_r    <= '0;
      dec_r        <= '0;
      decmask_r    <= '0;
      msi_pend_r   <= '0;
      msi_mask_r   <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_FIFO_MODE: fifo_mode_r <= cfg_wdata;
          CFG_LINK_UP:   link_up_r   <= cfg_wdata;
          default: ;
        endcase
      end

      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (res_go) begin
        s1_valid_r <= 1'b0;
      end

      // Advance the result into the output register, or park it in the skid.
      if (res_go) begin
        if (!out_valid_r || out_take) begin
          out_valid_r <= 1'b1;
        end else begin
          skid_valid_r <= 1'b1;
        end
      end else if (out_take) begin
        out_valid_r  <= skid_valid_r;
        skid_valid_r <= 1'b0;
      end

      pend_r     <= pend_nxt;
      imask_r    <= imask_nxt;
      bridge_r   <= bridge_nxt;
      ovf_r      <= ovf_nxt;
      msib_hi_r  <= msib_hi_nxt;
      msib_lo_r  <= msib_lo_nxt;
      dec_r      <= dec_nxt;
      decmask_r  <= decmask_nxt;
      msi_pend_r <= msi_pend_nxt;
      msi_mask_r <= msi_mask_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r    <= op_t'(in_operation);
      s1_addr_r  <= in_reg_address;
      s1_data_r  <= in_write_data;
      s1_line_r  <= in_irq_line;
      s1_level_r <= in_irq_level;
    end
    if (res_go) begin
      if (!out_valid_r || out_take) begin
        out_r <= res;
      end else begin
        skid_r <= res;
      end
    end else if (out_take && skid_valid_r) begin
      out_r <= skid_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_read_data    = out_r.read_data;
  assign out_irq_out      = out_r.irq_out;
  assign out_msi_irq_low  = out_r.msi_irq_low;
  assign out_msi_irq_high = out_r.msi_irq_high;
  assign out_bridge_on    = out_r.bridge_on;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r) else $error("skid holds a beat ahead of output");
  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |=> ovf_r) else $error("overflow flag cleared");
  a_push_sets_pend: assert property (@(posedge clk) disable iff (!rst_n)
    ring_ctl.push |=> pend_r) else $error("queued event left INTX clear");
  a_stall_needs_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r) else $error("stall with empty pipe");

endmodule
`default_nettype wire
